>>> sv/array_list_edit_engine_defines.svh
// Assertion macros shared by the checker of the array list edit engine.
// Depends on nothing; every macro expects clk and rst_n in scope.
`ifndef ARRAY_LIST_EDIT_ENGINE_DEFINES_SVH
`define ARRAY_LIST_EDIT_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ALEE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ALEE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/alee_pkg.sv
// Package of the array list edit engine: opcodes, status codes, widths,
// and the command and status structs between controller and datapath.
`timescale 1ns / 1ps
`default_nettype none

package alee_pkg;

    localparam int DEPTH_DEF  = 16;
    localparam int DATA_W_DEF = 16;

    localparam int OP_W      = 3;
    localparam int VALUE_W   = 16;
    localparam int POS_W     = 5;
    localparam int STATUS_W  = 2;
    localparam int CNT_OUT_W = 5;

    localparam logic [OP_W-1:0] OP_INS_AT    = 3'd0;
    localparam logic [OP_W-1:0] OP_SORT_INS  = 3'd1;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_ALL   = 3'd4;
    localparam logic [OP_W-1:0] OP_PAL       = 3'd5;
    localparam logic [OP_W-1:0] OP_READ      = 3'd6;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd7;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic            start;
        logic            shift_step;
        logic            compact_step;
        logic            pal_step;
        logic            read_cap;
        logic            load_out;
        logic [OP_W-1:0] op;
    } cmd_t;

    typedef struct packed {
        logic quick;
        logic shift_end;
        logic compact_end;
        logic pal_end;
    } stat_t;

endpackage

`default_nettype wire

>>> sv/array_list_edit_engine.sv
// Channel  Dir  Signals                     Contents
// s_axis   in   tvalid tready tdata tuser   edit command: opcode, value, position
// m_axis   out  tvalid tready tdata         one result per command
//
// One command is in work at a time; the walks move one entry per cycle through
// the single write port of the entry memory. The output register lets the next
// command be accepted while a result waits; a stalled result holds the following
// one back. After reset the array is empty; slots above the count are never read.
// Top level of the array list edit engine. Depends on alee_pkg, alee_ctrl, alee_dp.
`timescale 1ns / 1ps
`default_nettype none

module array_list_edit_engine #(
    parameter int DEPTH  = alee_pkg::DEPTH_DEF,
    parameter int DATA_W = alee_pkg::DATA_W_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // value[15:0], position[20:16], zero[23:21]
    input  wire  [2:0]  s_axis_tuser,  // opcode[2:0]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata   // status[1:0], read_value[17:2],
                                       // removed_count[22:18], is_palindrome[23],
                                       // entry_count[28:24], zero[31:29]
);

    alee_pkg::cmd_t  cmd;
    alee_pkg::stat_t stat;

    logic [alee_pkg::STATUS_W-1:0]  status;
    logic [alee_pkg::VALUE_W-1:0]   read_value;
    logic [alee_pkg::CNT_OUT_W-1:0] removed_count;
    logic                           is_palindrome;
    logic [alee_pkg::CNT_OUT_W-1:0] entry_count;

    alee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    alee_dp #(
        .DEPTH  (DEPTH),
        .DATA_W (DATA_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_value      (s_axis_tdata[15:0]),
        .in_position   (s_axis_tdata[20:16]),
        .status        (status),
        .read_value    (read_value),
        .removed_count (removed_count),
        .is_palindrome (is_palindrome),
        .entry_count   (entry_count)
    );

    assign m_axis_tdata = {3'b000, entry_count, is_palindrome, removed_count,
                           read_value, status};

endmodule

`default_nettype wire

>>> sv/alee_dp.sv
// Datapath of the array list edit engine: entry memory, count, walk pointers,
// pending result and output register. Depends on alee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alee_dp #(
    parameter int DEPTH  = alee_pkg::DEPTH_DEF,
    parameter int DATA_W = alee_pkg::DATA_W_DEF
) (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire alee_pkg::cmd_t                   cmd,
    output alee_pkg::stat_t                       stat,
    input  wire signed [alee_pkg::VALUE_W-1:0]    in_value,
    input  wire        [alee_pkg::POS_W-1:0]      in_position,
    output logic       [alee_pkg::STATUS_W-1:0]   status,
    output logic signed [alee_pkg::VALUE_W-1:0]   read_value,
    output logic       [alee_pkg::CNT_OUT_W-1:0]  removed_count,
    output logic                                  is_palindrome,
    output logic       [alee_pkg::CNT_OUT_W-1:0]  entry_count
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > alee_pkg::POS_W) ? CNT_W : alee_pkg::POS_W;
    localparam int EXT_W  = (DATA_W > alee_pkg::VALUE_W) ? DATA_W : alee_pkg::VALUE_W;

    // Slots at or above the count are never read, so the memory needs no reset.
    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ptr_reg, ptr_next;
    logic [CNT_W-1:0]  ptr2_reg, ptr2_next;
    logic              found_reg, found_next;
    logic [DATA_W-1:0] v_reg;
    logic [CMP_W-1:0]  pos_reg;

    logic [alee_pkg::STATUS_W-1:0]  res_status_reg;
    logic [alee_pkg::VALUE_W-1:0]   res_read_reg;
    logic [CMP_W-1:0]               res_rem_reg;
    logic                           res_pal_reg;

    logic [alee_pkg::STATUS_W-1:0]  status_reg;
    logic [alee_pkg::VALUE_W-1:0]   read_value_reg;
    logic [alee_pkg::CNT_OUT_W-1:0] removed_count_reg;
    logic                           is_palindrome_reg;
    logic [alee_pkg::CNT_OUT_W-1:0] entry_count_reg;

    logic signed [EXT_W-1:0] val_ext;
    logic signed [EXT_W-1:0] rd_ext;
    logic [DATA_W-1:0]       v_in;
    logic [CMP_W-1:0]        pos_in_ext;
    logic [CMP_W-1:0]        cnt_ext;
    logic [CNT_W-1:0]        count_m1;
    logic [CNT_W-1:0]        half_m1;
    logic                    full;
    logic [alee_pkg::STATUS_W-1:0] err;

    logic              move;
    logic              drop;
    logic              keep;
    logic              mismatch;
    logic [CNT_W-1:0]  j_final;
    logic [CNT_W-1:0]  rem_final;

    logic              we;
    logic [CNT_W-1:0]  waddr_w;
    logic [DATA_W-1:0] wdata;
    logic [CMP_W-1:0]  raddr_a_w;
    logic [CNT_W-1:0]  raddr_b_w;

    assign val_ext    = EXT_W'(in_value);
    assign v_in       = val_ext[DATA_W-1:0];
    assign rd_ext     = EXT_W'($signed(rdata_a_reg));
    assign pos_in_ext = CMP_W'(in_position);
    assign cnt_ext    = CMP_W'(count_reg);
    assign count_m1   = count_reg - CNT_W'(1);
    assign half_m1    = (count_reg >> 1) - CNT_W'(1);
    assign full       = (count_reg == CNT_W'(DEPTH));

    assign status        = status_reg;
    assign read_value    = read_value_reg;
    assign removed_count = removed_count_reg;
    assign is_palindrome = is_palindrome_reg;
    assign entry_count   = entry_count_reg;

    always_comb
    begin
        err = alee_pkg::ST_OK;
        unique case (cmd.op) inside
            alee_pkg::OP_INS_AT:
            begin
                if (full)
                    err = alee_pkg::ST_FULL;
                else if (pos_in_ext > cnt_ext)
                    err = alee_pkg::ST_BAD_POS;
            end
            alee_pkg::OP_SORT_INS:
            begin
                if (full)
                    err = alee_pkg::ST_FULL;
            end
            alee_pkg::OP_DEL_AT, alee_pkg::OP_READ:
            begin
                if (pos_in_ext >= cnt_ext)
                    err = alee_pkg::ST_BAD_POS;
            end
            alee_pkg::OP_DEL_FIRST, alee_pkg::OP_DEL_ALL:
            begin
                if (count_reg == '0)
                    err = alee_pkg::ST_NOT_FOUND;
            end
            default:
            begin
                err = alee_pkg::ST_OK;
            end
        endcase
    end

    // Shift walk: move the entry below the pointer up one slot, or drop the value in.
    assign move = (ptr_reg != '0) &&
                  ((cmd.op == alee_pkg::OP_INS_AT) ? (CMP_W'(ptr_reg) > pos_reg)
                                                   : ($signed(rdata_a_reg) > $signed(v_reg)));

    // Compaction walk: ptr reads, ptr2 writes back the entries that stay.
    always_comb
    begin
        drop = 1'b0;
        case (cmd.op)
            alee_pkg::OP_DEL_AT:    drop = (CMP_W'(ptr_reg) == pos_reg);
            alee_pkg::OP_DEL_FIRST: drop = (rdata_a_reg == v_reg) && !found_reg;
            default:                drop = (rdata_a_reg == v_reg);
        endcase
    end
    assign keep      = !drop;
    assign j_final   = ptr2_reg + CNT_W'(keep);
    assign rem_final = count_reg - j_final;
    assign mismatch  = (rdata_a_reg != rdata_b_reg);

    assign stat.quick       = (err != alee_pkg::ST_OK) || (cmd.op == alee_pkg::OP_CLEAR) ||
                              ((cmd.op == alee_pkg::OP_PAL) && (count_reg < CNT_W'(2)));
    assign stat.shift_end   = !move;
    assign stat.compact_end = (ptr_reg == count_m1);
    assign stat.pal_end     = mismatch || (ptr_reg == half_m1);

    // Read addresses: the walks fetch one step ahead so one entry moves per cycle.
    always_comb
    begin
        raddr_a_w = '0;
        raddr_b_w = count_m1;
        if (cmd.start)
        begin
            if (cmd.op == alee_pkg::OP_READ)
                raddr_a_w = pos_in_ext;
            else if ((cmd.op == alee_pkg::OP_INS_AT) || (cmd.op == alee_pkg::OP_SORT_INS))
                raddr_a_w = (count_reg != '0) ? CMP_W'(count_m1) : '0;
        end
        else if (cmd.shift_step)
        begin
            raddr_a_w = (ptr_reg >= CNT_W'(2)) ? CMP_W'(ptr_reg - CNT_W'(2)) : '0;
        end
        else if (cmd.compact_step)
        begin
            raddr_a_w = (ptr_reg < count_m1) ? CMP_W'(ptr_reg + CNT_W'(1)) : '0;
        end
        else if (cmd.pal_step)
        begin
            raddr_a_w = CMP_W'(ptr_reg + CNT_W'(1));
            raddr_b_w = ptr2_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        we      = 1'b0;
        waddr_w = ptr_reg;
        wdata   = rdata_a_reg;
        if (cmd.shift_step)
        begin
            we    = 1'b1;
            wdata = move ? rdata_a_reg : v_reg;
        end
        else if (cmd.compact_step)
        begin
            we      = keep;
            waddr_w = ptr2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr_w[ADDR_W-1:0]] <= wdata;
        rdata_a_reg <= mem[raddr_a_w[ADDR_W-1:0]];
        rdata_b_reg <= mem[raddr_b_w[ADDR_W-1:0]];
    end

    always_comb
    begin
        count_next = count_reg;
        ptr_next   = ptr_reg;
        ptr2_next  = ptr2_reg;
        found_next = found_reg;
        if (cmd.start)
        begin
            ptr_next   = ((cmd.op == alee_pkg::OP_INS_AT) || (cmd.op == alee_pkg::OP_SORT_INS))
                         ? count_reg : '0;
            ptr2_next  = (cmd.op == alee_pkg::OP_PAL) ? count_m1 : '0;
            found_next = 1'b0;
            if (cmd.op == alee_pkg::OP_CLEAR)
                count_next = '0;
        end
        else if (cmd.shift_step)
        begin
            if (move)
                ptr_next = ptr_reg - CNT_W'(1);
            else
                count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.compact_step)
        begin
            found_next = found_reg || drop;
            ptr_next   = ptr_reg + CNT_W'(1);
            ptr2_next  = j_final;
            if (stat.compact_end)
                count_next = j_final;
        end
        else if (cmd.pal_step)
        begin
            ptr_next  = ptr_reg + CNT_W'(1);
            ptr2_next = ptr2_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            ptr2_reg  <= '0;
            found_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ptr_reg   <= ptr_next;
            ptr2_reg  <= ptr2_next;
            found_reg <= found_next;
        end
    end

    // Item operands, pending result and output register.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            v_reg          <= v_in;
            pos_reg        <= pos_in_ext;
            res_status_reg <= err;
            res_read_reg   <= '0;
            res_rem_reg    <= (cmd.op == alee_pkg::OP_CLEAR) ? cnt_ext : '0;
            res_pal_reg    <= (cmd.op == alee_pkg::OP_PAL);
        end
        if (cmd.compact_step && stat.compact_end)
        begin
            res_rem_reg    <= CMP_W'(rem_final);
            res_status_reg <= (rem_final == '0) ? alee_pkg::ST_NOT_FOUND : alee_pkg::ST_OK;
        end
        if (cmd.pal_step && mismatch)
            res_pal_reg <= 1'b0;
        if (cmd.read_cap)
            res_read_reg <= rd_ext[alee_pkg::VALUE_W-1:0];
        if (cmd.load_out)
        begin
            status_reg        <= res_status_reg;
            read_value_reg    <= res_read_reg;
            removed_count_reg <= res_rem_reg[alee_pkg::CNT_OUT_W-1:0];
            is_palindrome_reg <= res_pal_reg;
            entry_count_reg   <= cnt_ext[alee_pkg::CNT_OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire

>>> sv/alee_ctrl.sv
// Controller of the array list edit engine: sequences one item at a time
// through the datapath walks and owns both handshakes. Depends on alee_pkg.
`timescale 1ns / 1ps
`default_nettype none

module alee_ctrl (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire  [alee_pkg::OP_W-1:0]    in_op,
    output logic                         out_valid,
    input  wire                          out_ready,
    output alee_pkg::cmd_t               cmd,
    input  wire alee_pkg::stat_t         stat
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SHIFT   = 3'd1;
    localparam logic [2:0] S_COMPACT = 3'd2;
    localparam logic [2:0] S_PAL     = 3'd3;
    localparam logic [2:0] S_READ    = 3'd4;
    localparam logic [2:0] S_FINISH  = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic [alee_pkg::OP_W-1:0] op_reg;
    logic                      out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.op         = op_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.op = in_op;
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (stat.quick)
                        state_next = S_FINISH;
                    else
                    begin
                        unique case (in_op) inside
                            alee_pkg::OP_INS_AT, alee_pkg::OP_SORT_INS:
                                state_next = S_SHIFT;
                            alee_pkg::OP_DEL_AT, alee_pkg::OP_DEL_FIRST, alee_pkg::OP_DEL_ALL:
                                state_next = S_COMPACT;
                            alee_pkg::OP_PAL:
                                state_next = S_PAL;
                            alee_pkg::OP_READ:
                                state_next = S_READ;
                            default:
                                state_next = S_FINISH;
                        endcase
                    end
                end
            end
            S_SHIFT:
            begin
                cmd.shift_step = 1'b1;
                if (stat.shift_end)
                    state_next = S_FINISH;
            end
            S_COMPACT:
            begin
                cmd.compact_step = 1'b1;
                if (stat.compact_end)
                    state_next = S_FINISH;
            end
            S_PAL:
            begin
                cmd.pal_step = 1'b1;
                if (stat.pal_end)
                    state_next = S_FINISH;
            end
            S_READ:
            begin
                cmd.read_cap = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                // The result waits here only while the previous one is still unread.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= alee_pkg::OP_INS_AT;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cmd.start)
                op_reg <= in_op;
        end
    end

endmodule

`default_nettype wire

>>> sv/alee_checker.sv
// Port-level checker of the array list edit engine, bound to the top level.
// Depends on array_list_edit_engine_defines.svh and alee_pkg.
`timescale 1ns / 1ps
`default_nettype none

`include "array_list_edit_engine_defines.svh"

module alee_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);

    logic       refused;
    logic       out_refused;
    logic       has_side;
    logic       no_rem;
    logic       took_in;
    logic       out_stall;
    logic [1:0] st;

    assign st          = m_axis_tdata[1:0];
    assign refused     = (st != alee_pkg::ST_OK);
    assign out_refused = m_axis_tvalid && refused;
    assign has_side    = (m_axis_tdata[17:2] != '0) || m_axis_tdata[23];
    assign no_rem      = (m_axis_tdata[22:18] == '0);
    assign took_in     = s_axis_tvalid && s_axis_tready;
    assign out_stall   = m_axis_tvalid && !m_axis_tready;

    // A refused command reports no removal, no read data and no palindrome.
    `ALEE_ASSERT_IMP(a_refused_clean, out_refused, no_rem && !has_side, "refused with data")

    // Read data or a palindrome answer never comes with a removal.
    `ALEE_ASSERT_IMP(a_query_no_rem, m_axis_tvalid && has_side, no_rem, "query with removal")

    // Commands are taken one at a time.
    `ALEE_ASSERT_NXT(a_one_in_work, took_in, !s_axis_tready, "second command taken")

    // A stalled result stays put.
    `ALEE_ASSERT_NXT(a_valid_hold, out_stall, m_axis_tvalid, "stalled result dropped")
    `ALEE_ASSERT_NXT(a_data_hold, out_stall, $stable(m_axis_tdata), "stalled result changed")

endmodule

bind array_list_edit_engine alee_checker u_alee_checker (.*);

`default_nettype wire

>>> tb/sv/alee_edit_checker.sv
// Checker of the array list edit engine: watches both stream channels, keeps its own
// copy of the array, predicts one result per accepted command and compares it.
// Depends on alee_pkg for the opcode and status codes.
`timescale 1ns / 1ps

module alee_edit_checker #(
    parameter int DEPTH = alee_pkg::DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          array_count
);

    import alee_pkg::*;

    // Field order matches the result word, so the lowest field comes last.
    typedef struct packed {
        logic [4:0]         entry_count;
        logic               palindrome;
        logic [4:0]         removed;
        logic signed [15:0] read_value;
        logic [1:0]         status;
    } edit_outcome_t;

    logic signed [15:0] slots [DEPTH];
    int                 fill;
    edit_outcome_t      outcome_q [$];
    int                 mismatches;
    edit_outcome_t      got;
    edit_outcome_t      want;

    function automatic void shift_in(int at, logic signed [15:0] v);
        for (int i = fill; i > at; i--)
            slots[i] = slots[i-1];
        slots[at] = v;
        fill++;
    endfunction

    function automatic void drop_slot(int at);
        for (int i = at; i + 1 < fill; i++)
            slots[i] = slots[i+1];
        slots[fill-1] = '0;
        fill--;
    endfunction

    function automatic edit_outcome_t predict_edit(logic [2:0] op, logic signed [15:0] v,
                                                   int pos);
        edit_outcome_t r;
        int            k;
        int            j;
        int            hit;
        r = '0;
        case (op)
            OP_INS_AT:
                if (fill >= DEPTH)
                    r.status = ST_FULL;
                else if (pos > fill)
                    r.status = ST_BAD_POS;
                else
                    shift_in(pos, v);
            OP_SORT_INS:
                if (fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    // The new word lands right after the last entry not greater than it.
                    k = fill;
                    while (k > 0 && slots[k-1] > v)
                        k--;
                    shift_in(k, v);
                end
            OP_DEL_AT:
                if (pos >= fill)
                    r.status = ST_BAD_POS;
                else
                begin
                    drop_slot(pos);
                    r.removed = 1;
                end
            OP_DEL_FIRST:
            begin
                hit = -1;
                for (k = 0; k < fill; k++)
                    if (hit < 0 && slots[k] == v)
                        hit = k;
                if (hit < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    drop_slot(hit);
                    r.removed = 1;
                end
            end
            OP_DEL_ALL:
            begin
                j = 0;
                for (k = 0; k < fill; k++)
                    if (slots[k] != v)
                    begin
                        slots[j] = slots[k];
                        j++;
                    end
                r.removed = 5'(fill - j);
                for (k = j; k < fill; k++)
                    slots[k] = '0;
                fill = j;
                if (r.removed == 0)
                    r.status = ST_NOT_FOUND;
            end
            OP_PAL:
            begin
                r.palindrome = 1'b1;
                for (k = 0; k < fill / 2; k++)
                    if (slots[k] != slots[fill-1-k])
                        r.palindrome = 1'b0;
            end
            OP_READ:
                if (pos >= fill)
                    r.status = ST_BAD_POS;
                else
                    r.read_value = slots[pos];
            OP_CLEAR:
            begin
                r.removed = 5'(fill);
                for (k = 0; k < DEPTH; k++)
                    slots[k] = '0;
                fill = 0;
            end
        endcase
        r.entry_count = 5'(fill);
        return r;
    endfunction

    function automatic void compare_field(string field_name, int expected_val, int actual_val);
        if (expected_val != actual_val)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field_name, expected_val, actual_val);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
                slots[i] = '0;
            fill = 0;
            outcome_q.delete();
        end
        else
        begin
            // Push before popping, so a command and a result in the same cycle stay ordered.
            if (s_axis_tvalid && s_axis_tready)
                outcome_q.push_back(predict_edit(s_axis_tuser, s_axis_tdata[15:0],
                                                 int'(s_axis_tdata[20:16])));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[28:0];
                if (outcome_q.size() == 0)
                begin
                    $display("%0t: result transfer with nothing expected, expected none, actual %h",
                             $time, m_axis_tdata);
                    mismatches++;
                end
                else
                begin
                    want = outcome_q.pop_front();
                    compare_field("status", want.status, got.status);
                    compare_field("read_value", want.read_value, got.read_value);
                    compare_field("removed_count", want.removed, got.removed);
                    compare_field("is_palindrome", want.palindrome, got.palindrome);
                    compare_field("entry_count", want.entry_count, got.entry_count);
                end
            end
        end
        fail_count  <= mismatches;
        pending     <= outcome_q.size();
        array_count <= fill;
    end

endmodule

>>> tb/sv/testbench.sv
// Top of the array list edit engine testbench: clock, reset, command stimulus and
// the result receiver. Depends on alee_pkg, array_list_edit_engine and alee_edit_checker.
`timescale 1ns / 1ps

module testbench;

    import alee_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 1800;
    localparam int PHASE_ITEMS  = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 1000000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;

    int fail_count;
    int pending;
    int array_count;
    int tx_idle    = 0;
    int rx_stall   = 0;
    bit hold_req   = 1'b0;
    int items_sent = 0;
    int cycles     = 0;

    array_list_edit_engine i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    alee_edit_checker #(.DEPTH(DEPTH)) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .array_count   (array_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stalls, plus one long hold-off that it counts out itself.
    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_stall);
        end
    end

    // Offers one command and waits for its transfer, then idles at random.
    task automatic send_edit(logic [2:0] op, logic [15:0] v, int pos);
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, 5'(pos), v};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
        while ($urandom_range(0, 99) < tx_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // A few extreme and small words give plenty of duplicates for the match searches.
    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4, 5:    return 16'($urandom_range(1, 4));
            default: return 16'($urandom);
        endcase
    endfunction

    // Mostly positions near the current fill, so that edits land inside the array.
    function automatic int pick_position();
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, DEPTH);
        return $urandom_range(0, array_count);
    endfunction

    initial
    begin
        logic [15:0] half [DEPTH/2];
        logic [2:0]  op;
        bit          grow;
        bit          held;
        bit          paused;
        int          start;
        int          n;
        int          r;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_INS_AT;
        rst_n         <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty array, both ends of the sorted order, full array, last slot.
        send_edit(OP_PAL, 16'h0000, 0);
        send_edit(OP_READ, 16'h0000, 0);
        send_edit(OP_DEL_FIRST, 16'hffff, 0);
        send_edit(OP_DEL_ALL, 16'hffff, 0);
        send_edit(OP_SORT_INS, 16'h7fff, 0);
        send_edit(OP_SORT_INS, 16'h8000, 0);
        send_edit(OP_INS_AT, 16'h0005, 3);
        send_edit(OP_CLEAR, 16'h0000, 0);
        repeat (DEPTH) send_edit(OP_INS_AT, 16'h0007, 0);
        send_edit(OP_INS_AT, 16'h0001, DEPTH);
        send_edit(OP_SORT_INS, 16'h0001, 0);
        send_edit(OP_READ, 16'h0000, DEPTH);
        send_edit(OP_PAL, 16'h0000, 0);
        send_edit(OP_DEL_AT, 16'h0000, DEPTH - 1);
        send_edit(OP_DEL_ALL, 16'h0007, 0);

        grow   = 1'b1;
        held   = 1'b0;
        paused = 1'b0;
        start  = items_sent;
        while (items_sent - start < RANDOM_ITEMS)
        begin
            case (((items_sent - start) / PHASE_ITEMS) % 4)
                0:
                begin
                    tx_idle  = 0;
                    rx_stall = 0;
                end
                1:
                begin
                    tx_idle  = 67;
                    rx_stall = 0;
                end
                2:
                begin
                    tx_idle  = 0;
                    rx_stall = 67;
                end
                default:
                begin
                    tx_idle  = 38;
                    rx_stall = 38;
                end
            endcase

            if (!held && items_sent - start >= 400)
            begin
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && items_sent - start >= 1000)
            begin
                paused = 1'b1;
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
            end

            if (array_count >= DEPTH - 1 && $urandom_range(0, 3) == 0)
                grow = 1'b0;
            else if (array_count <= 1 || $urandom_range(0, 49) == 0)
                grow = ~grow | (array_count <= 1);

            if ($urandom_range(0, 29) == 0)
            begin
                // Build a mirrored array, sometimes spoil it, then ask for the palindrome test.
                n = $urandom_range(0, DEPTH);
                for (int i = 0; i < DEPTH / 2; i++)
                    half[i] = pick_value();
                send_edit(OP_CLEAR, pick_value(), pick_position());
                for (int i = 0; i < n; i++)
                    send_edit(OP_INS_AT, (i < (n + 1) / 2) ? half[i] : half[n-1-i], i);
                if (n > 0 && $urandom_range(0, 2) == 0)
                    send_edit(OP_INS_AT, pick_value(), $urandom_range(0, n));
                send_edit(OP_PAL, pick_value(), pick_position());
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (grow)
                    op = (r < 30) ? OP_INS_AT : (r < 60) ? OP_SORT_INS :
                         (r < 68) ? OP_DEL_AT : (r < 76) ? OP_DEL_FIRST :
                         (r < 80) ? OP_DEL_ALL : (r < 86) ? OP_PAL :
                         (r < 98) ? OP_READ : OP_CLEAR;
                else
                    op = (r < 8) ? OP_INS_AT : (r < 16) ? OP_SORT_INS :
                         (r < 41) ? OP_DEL_AT : (r < 61) ? OP_DEL_FIRST :
                         (r < 71) ? OP_DEL_ALL : (r < 79) ? OP_PAL :
                         (r < 97) ? OP_READ : OP_CLEAR;
                send_edit(op, pick_value(), pick_position());
            end
        end

        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
